@@ hw/rtl/orc_pkg.sv @@
// orc_pkg: shared types, register indexes and constants for the overload rate controller.
// No dependencies; imported by every orc_* module and the top level.
package orc_pkg;

    localparam int NUM_INTERFACES_DEF = 4;
    localparam int NUM_SPEED_REGS     = 4;
    localparam int SPEED_SEL_W        = $clog2(NUM_SPEED_REGS);

    localparam int CPU_W       = 14;
    localparam int THR_W       = 7;
    localparam int SPEED_W     = 17;
    localparam int BYTES_W     = 40;
    localparam int RAND_W      = 7;
    localparam int RATE_W      = 7;
    localparam int RUN_W       = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 17;

    // limit pipeline: speed*thr, /100 by reciprocal, then byte threshold
    localparam int PROD_W         = SPEED_W + THR_W;
    localparam int DIV100_MULT_W  = 25;
    localparam int DIV100_SHIFT   = 31;
    localparam logic [DIV100_MULT_W-1:0] DIV100_MULT = 25'd21474837;
    localparam int LIMIT_W        = 18;
    localparam int QUOT_W         = 16;
    localparam int BYTE_LIM_W     = 36;
    localparam int MEGA_W         = 20;
    localparam logic [MEGA_W-1:0] MEGA = 20'd1000000;
    localparam int LIMIT_LATENCY  = 3;
    localparam int HOLD_W         = $clog2(LIMIT_LATENCY + 1);

    localparam logic [RATE_W-1:0] RISE_LOW   = 7'd5;
    localparam logic [RATE_W-1:0] RISE_HIGH  = 7'd2;
    localparam logic [RATE_W-1:0] RISE_KNEE  = 7'd20;
    localparam logic [RATE_W-1:0] STEP_BIG   = 7'd10;
    localparam logic [RATE_W-1:0] FALL_SMALL = 7'd1;
    localparam logic [RATE_W-1:0] RATE_MAX   = 7'd100;
    localparam logic [RUN_W-1:0]  RUN_MAX       = 4'd15;
    localparam logic [RUN_W-1:0]  OVERLOAD_KNEE = 4'd4;
    localparam logic [RUN_W-1:0]  CALM_KNEE     = 4'd5;

    localparam logic [THR_W-1:0]   CPU_THR_RST = 7'd80;
    localparam logic [THR_W-1:0]   NET_THR_RST = 7'd70;
    localparam logic [SPEED_W-1:0] SPEED_RST   = 17'd1000;

    localparam logic MODE_EVAL  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CPU_THR = 8'd0,
        REG_NET_THR = 8'd1,
        REG_CTRL_EN = 8'd2,
        REG_SPEED_0 = 8'd3,
        REG_SPEED_1 = 8'd4,
        REG_SPEED_2 = 8'd5,
        REG_SPEED_3 = 8'd6
    } cfg_index_t;

    typedef struct packed {
        logic [THR_W-1:0]                         cpu_thr;
        logic [THR_W-1:0]                         net_thr;
        logic                                     ctrl_en;
        logic [NUM_SPEED_REGS-1:0][SPEED_W-1:0]   link_speed;
    } cfg_t;

endpackage

@@ hw/rtl/overload_rate_controller.sv @@
// overload_rate_controller: top level; config registers, per-interface lanes, merge/update core.
// Depends on orc_pkg, orc_cfg, orc_lane, orc_core.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  item     | item_valid/item_stall     | mode, cpu_rate, tx/rx_bytes_0..3, random_value
//  result   | result_valid/result_stall | load_rate, reject
//  cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
//  One item per cycle sustained while item_stall is low; the result is registered in the output
//  register, or in the skid entry when the output register is held. Output register plus one
//  skid entry; from the output side, item_stall rises only when the skid entry is full.
//  Each lane's byte limit is a 3-stage multiply pipeline off the config registers, so the
//  item channel stalls after reset and after every config write while the limits settle.
module overload_rate_controller #(
    parameter int NUM_INTERFACES = orc_pkg::NUM_INTERFACES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            mode,
    input  logic [orc_pkg::CPU_W-1:0]       cpu_rate,
    input  logic [orc_pkg::BYTES_W-1:0]     tx_bytes_0,
    input  logic [orc_pkg::BYTES_W-1:0]     rx_bytes_0,
    input  logic [orc_pkg::BYTES_W-1:0]     tx_bytes_1,
    input  logic [orc_pkg::BYTES_W-1:0]     rx_bytes_1,
    input  logic [orc_pkg::BYTES_W-1:0]     tx_bytes_2,
    input  logic [orc_pkg::BYTES_W-1:0]     rx_bytes_2,
    input  logic [orc_pkg::BYTES_W-1:0]     tx_bytes_3,
    input  logic [orc_pkg::BYTES_W-1:0]     rx_bytes_3,
    input  logic [orc_pkg::RAND_W-1:0]      random_value,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [orc_pkg::RATE_W-1:0]      load_rate,
    output logic                            reject,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [orc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [orc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import orc_pkg::*;

    localparam int LANES = (NUM_INTERFACES < NUM_SPEED_REGS) ? NUM_INTERFACES : NUM_SPEED_REGS;

    cfg_t                                   cfg;
    logic                                   hold;
    logic [NUM_SPEED_REGS-1:0][BYTES_W-1:0] tx_bytes, rx_bytes;
    logic [LANES-1:0]                       lane_hit;

    assign tx_bytes = {tx_bytes_3, tx_bytes_2, tx_bytes_1, tx_bytes_0};
    assign rx_bytes = {rx_bytes_3, rx_bytes_2, rx_bytes_1, rx_bytes_0};

    orc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .hold      (hold)
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        orc_lane u_lane (
            .clk        (clk),
            .link_speed (cfg.link_speed[i]),
            .net_thr    (cfg.net_thr),
            .tx_bytes   (tx_bytes[i]),
            .rx_bytes   (rx_bytes[i]),
            .hit        (lane_hit[i])
        );
    end

    orc_core #(
        .LANES (LANES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .hold         (hold),
        .mode         (mode),
        .cpu_rate     (cpu_rate),
        .random_value (random_value),
        .lane_hit     (lane_hit),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .load_rate    (load_rate),
        .reject       (reject)
    );

endmodule

@@ hw/rtl/orc_cfg.sv @@
// orc_cfg: configuration register file and post-write hold timer.
// Depends on orc_pkg.
module orc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [orc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [orc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output orc_pkg::cfg_t                  cfg,
    output logic                           hold
);
    import orc_pkg::*;

    cfg_t                   cfg_reg, cfg_next;
    logic [HOLD_W-1:0]      hold_reg, hold_next;
    logic                   wr;
    logic [CFG_INDEX_W-1:0] idx_off;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;
    assign idx_off   = cfg_index - CFG_INDEX_W'(REG_SPEED_0);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (cfg_index) inside
                REG_CPU_THR: cfg_next.cpu_thr = cfg_data[THR_W-1:0];
                REG_NET_THR: cfg_next.net_thr = cfg_data[THR_W-1:0];
                REG_CTRL_EN: cfg_next.ctrl_en = cfg_data[0];
                [REG_SPEED_0:REG_SPEED_3]:
                    cfg_next.link_speed[idx_off[SPEED_SEL_W-1:0]] = cfg_data[SPEED_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // limits trail the registers by the lane pipeline depth
    always_comb
    begin
        if (wr)
            hold_next = HOLD_W'(LIMIT_LATENCY);
        else if (hold_reg != '0)
            hold_next = hold_reg - 1'b1;
        else
            hold_next = hold_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cpu_thr    <= CPU_THR_RST;
            cfg_reg.net_thr    <= NET_THR_RST;
            cfg_reg.ctrl_en    <= 1'b0;
            cfg_reg.link_speed <= {NUM_SPEED_REGS{SPEED_RST}};
            hold_reg           <= HOLD_W'(LIMIT_LATENCY);
        end
        else
        begin
            cfg_reg  <= cfg_next;
            hold_reg <= hold_next;
        end
    end

    assign cfg  = cfg_reg;
    assign hold = (hold_reg != '0);

endmodule

@@ hw/rtl/orc_lane.sv @@
// orc_lane: per-interface byte limit pipeline and tx/rx overload compare.
// Depends on orc_pkg.
module orc_lane (
    input  logic                        clk,
    input  logic [orc_pkg::SPEED_W-1:0] link_speed,
    input  logic [orc_pkg::THR_W-1:0]   net_thr,
    input  logic [orc_pkg::BYTES_W-1:0] tx_bytes,
    input  logic [orc_pkg::BYTES_W-1:0] rx_bytes,
    output logic                        hit
);
    import orc_pkg::*;

    localparam int RECIP_W = PROD_W + DIV100_MULT_W;
    localparam int Q3_W    = LIMIT_W + 2;

    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [RECIP_W-1:0]    recip;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [Q3_W-1:0]       q3;
    logic [BYTE_LIM_W-1:0] byte_lim_reg, byte_lim_next;

    // floor(b/1e6)*8/3 > L  <=>  b >= 1e6 * ceil(3*(L+1)/8)
    assign prod_next     = PROD_W'(link_speed) * PROD_W'(net_thr);
    assign recip         = RECIP_W'(prod_reg) * RECIP_W'(DIV100_MULT);
    assign limit_next    = recip[DIV100_SHIFT +: LIMIT_W];
    assign q3            = (Q3_W'(limit_reg) + 1'b1) * Q3_W'(3) + Q3_W'(7);
    assign byte_lim_next = BYTE_LIM_W'(q3[3 +: QUOT_W]) * BYTE_LIM_W'(MEGA);

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        limit_reg    <= limit_next;
        byte_lim_reg <= byte_lim_next;
    end

    assign hit = (tx_bytes >= BYTES_W'(byte_lim_reg)) | (rx_bytes >= BYTES_W'(byte_lim_reg));

endmodule

@@ hw/rtl/orc_core.sv @@
// orc_core: merges lane results, updates rate state, output register with skid.
// Depends on orc_pkg.
module orc_core #(
    parameter int LANES = orc_pkg::NUM_INTERFACES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         hold,
    input  logic                         mode,
    input  logic [orc_pkg::CPU_W-1:0]    cpu_rate,
    input  logic [orc_pkg::RAND_W-1:0]   random_value,
    input  logic [LANES-1:0]             lane_hit,
    input  orc_pkg::cfg_t                cfg,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [orc_pkg::RATE_W-1:0]   load_rate,
    output logic                         reject
);
    import orc_pkg::*;

    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [RUN_W-1:0]  orun_reg, orun_next;
    logic [RUN_W-1:0]  crun_reg, crun_next;
    logic [RUN_W-1:0]  orun_inc, crun_inc;
    logic [RATE_W:0]   rise_sum;
    logic [RATE_W-1:0] dec;
    logic              accept, cpu_hit, overloaded, rej_now, out_fire;

    logic              main_valid_reg, main_valid_next;
    logic [RATE_W-1:0] main_rate_reg, main_rate_next;
    logic              main_rej_reg, main_rej_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [RATE_W-1:0] skid_rate_reg, skid_rate_next;
    logic              skid_rej_reg, skid_rej_next;

    assign item_stall = skid_valid_reg | hold;
    assign accept     = item_valid & ~item_stall;
    assign out_fire   = main_valid_reg & ~result_stall;

    assign cpu_hit    = $signed(cpu_rate) > $signed(CPU_W'(cfg.cpu_thr));
    assign overloaded = cpu_hit | (|lane_hit);
    assign rej_now    = (mode == MODE_QUERY) & cfg.ctrl_en & (rate_reg > random_value);

    assign orun_inc = (orun_reg == RUN_MAX) ? RUN_MAX : orun_reg + 1'b1;
    assign crun_inc = (crun_reg == RUN_MAX) ? RUN_MAX : crun_reg + 1'b1;
    assign rise_sum = {1'b0, rate_reg}
                    + {1'b0, (rate_reg < RISE_KNEE) ? RISE_LOW : RISE_HIGH}
                    + {1'b0, (orun_inc > OVERLOAD_KNEE) ? STEP_BIG : {RATE_W{1'b0}}};
    assign dec      = (crun_inc < CALM_KNEE) ? FALL_SMALL : STEP_BIG;

    always_comb
    begin
        rate_next = rate_reg;
        orun_next = orun_reg;
        crun_next = crun_reg;
        if (accept && mode == MODE_EVAL)
        begin
            if (overloaded)
            begin
                crun_next = '0;
                orun_next = orun_inc;
                rate_next = (rise_sum > {1'b0, RATE_MAX}) ? RATE_MAX : rise_sum[RATE_W-1:0];
            end
            else
            begin
                orun_next = '0;
                crun_next = crun_inc;
                rate_next = (rate_reg > dec) ? rate_reg - dec : '0;
            end
        end
    end

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_rate_next  = main_rate_reg;
        main_rej_next   = main_rej_reg;
        skid_valid_next = skid_valid_reg;
        skid_rate_next  = skid_rate_reg;
        skid_rej_next   = skid_rej_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_rate_next  = skid_rate_reg;
                main_rej_next   = skid_rej_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_valid_next = 1'b1;
                main_rate_next  = rate_next;
                main_rej_next   = rej_now;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_rate_next  = rate_next;
                skid_rej_next   = rej_now;
            end
        end
        else if (out_fire)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg       <= '0;
            orun_reg       <= '0;
            crun_reg       <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            rate_reg       <= rate_next;
            orun_reg       <= orun_next;
            crun_reg       <= crun_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_rate_reg <= main_rate_next;
        main_rej_reg  <= main_rej_next;
        skid_rate_reg <= skid_rate_next;
        skid_rej_reg  <= skid_rej_next;
    end

    assign result_valid = main_valid_reg;
    assign load_rate    = main_rate_reg;
    assign reject       = main_rej_reg;

`ifndef SYNTH
    a_rate_max: assert property (@(posedge clk) disable iff (!rst_n)
        rate_reg <= RATE_MAX)
        else $error("rate above maximum");
    a_skid_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds data while output empty");
    a_query_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_QUERY) |=> $stable(rate_reg) && $stable(orun_reg))
        else $error("query changed state");
    a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(orun_reg != '0 && crun_reg != '0))
        else $error("both run counters nonzero");
    a_no_accept_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hold |-> !accept)
        else $error("transaction accepted while limits settle");
`endif

endmodule
